FILE: rtl/owsm_pkg.sv
// ============================================================================
// Omni wheel speed mixer package
// Shared widths, payload types, register indexes, sequencer states and the
// output rounding function of the three-wheel omni speed mixer.
// ============================================================================
package owsm_pkg;

    localparam int RATE_W     = 16;
    localparam int OUT_W      = 32;
    localparam int STEP_W     = 12;
    localparam int GAIN_W     = 16;
    localparam int WEIGHT_W   = 15;
    localparam int DZ_W       = 15;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Shared multiplier: signed 33 bit by signed 17 bit.
    localparam int OPA_W  = 33;
    localparam int OPB_W  = 17;
    localparam int PROD_W = OPA_W + OPB_W;

    // Wheel sums are kept in Q.34; every term stays well below 2^51.
    localparam int ACC_W      = 56;
    localparam int OUT_SHIFT  = 18;
    localparam int TURN_SHIFT = 14;
    localparam int SLIP_SHIFT = 4;
    localparam int HALF_SHIFT = 13;

    localparam logic [WEIGHT_W-1:0] SQRT3_HALF_Q14 = WEIGHT_W'(14189);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (OUT_SHIFT - 1);

    // Register reset values.
    localparam logic [STEP_W-1:0]   ACCEL_STEP_RST    = STEP_W'(20);
    localparam logic [GAIN_W-1:0]   LINEAR_GAIN_RST   = GAIN_W'(16384);
    localparam logic [GAIN_W-1:0]   TURN_GAIN_RST     = GAIN_W'(16384);
    localparam logic [GAIN_W-1:0]   SLIP_GAIN_RST     = GAIN_W'(256);
    localparam logic [WEIGHT_W-1:0] GRIP_WEIGHT_A_RST = WEIGHT_W'(6423);
    localparam logic [WEIGHT_W-1:0] GRIP_WEIGHT_B_RST = WEIGHT_W'(6423);
    localparam logic [WEIGHT_W-1:0] GRIP_WEIGHT_C_RST = WEIGHT_W'(3539);
    localparam logic [DZ_W-1:0]     SLIP_DEADZONE_RST = DZ_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_STEP    = 4'd0,
        CFG_LINEAR_GAIN   = 4'd1,
        CFG_TURN_GAIN     = 4'd2,
        CFG_SLIP_GAIN     = 4'd3,
        CFG_GRIP_WEIGHT_A = 4'd4,
        CFG_GRIP_WEIGHT_B = 4'd5,
        CFG_GRIP_WEIGHT_C = 4'd6,
        CFG_SLIP_DEADZONE = 4'd7
    } owsm_cfg_idx_t;

    typedef struct packed {
        logic signed [RATE_W-1:0] demand_x;
        logic signed [RATE_W-1:0] demand_y;
        logic signed [RATE_W-1:0] demand_turn;
        logic signed [RATE_W-1:0] yaw_correction;
    } owsm_cmd_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] wheel_one_rpm;
        logic signed [OUT_W-1:0] wheel_two_rpm;
        logic signed [OUT_W-1:0] wheel_three_rpm;
    } owsm_rsp_t;

    // An idle state, one state per multiplier issue slot, then a drain and a finish slot.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TURN,
        ST_SLIP,
        ST_LIN_Y,
        ST_LIN_X,
        ST_WGT_A,
        ST_WGT_B,
        ST_WGT_C,
        ST_GAIN_A,
        ST_GAIN_B,
        ST_GAIN_C,
        ST_LAST,
        ST_DONE
    } owsm_state_t;

    // Round a Q.34 sum to Q16.16 (halves toward plus infinity) and saturate.
    function automatic logic signed [OUT_W-1:0] owsm_finish(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0]           rnd;
        logic signed [ACC_W-OUT_SHIFT-1:0] q;
        logic [ACC_W-OUT_SHIFT-OUT_W:0]    hi;
        logic signed [OUT_W-1:0]           res;
        rnd = acc + ROUND_HALF;
        q   = rnd[ACC_W-1:OUT_SHIFT];
        hi  = q[ACC_W-OUT_SHIFT-1:OUT_W-1];
        if ((hi == '0) || (hi == '1))
        begin
            res = q[OUT_W-1:0];
        end
        else if (q[ACC_W-OUT_SHIFT-1])
        begin
            res = {1'b1, {(OUT_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(OUT_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

FILE: rtl/omni_wheel_speed_mixer.sv
// ============================================================================
// Omni wheel speed mixer
// Ramp-limited three-wheel omni inverse kinematics with a deadzoned slip term.
// ============================================================================
// Each transfer on the cmd channel is one control tick: demanded x, y and turn
// rates in Q3.12 and a yaw slip correction in Q8.8. The x demand is ramp
// limited against a kept reference, then the three wheel speeds are formed
// in Q.34, rounded once to Q16.16 rpm and saturated to 32 bits, and returned
// as one transfer on the rsp channel. All products go through one shared
// 33 x 17 bit signed multiplier with a registered output, issued once per
// cycle by a small sequencer: ten multiplies plus a drain step and a finish
// step. cmd_stall stays high while the sequencer is busy, so a new cmd
// transfer can only follow once the previous item has left the finish step.
// The finished result sits in an output register, so the block takes the
// next item while that result still waits; only when a second result is
// done before the first has been taken does the block hold in its finish
// step. Configuration registers are written through the cfg channel (always
// ready); the user must write them only while the block is idle, which the
// block itself does not enforce; writes to unknown indexes are ignored.
module omni_wheel_speed_mixer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  owsm_pkg::owsm_cmd_t               cmd,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output owsm_pkg::owsm_rsp_t               rsp,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [owsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [owsm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import owsm_pkg::*;

    // Configuration registers.
    logic [STEP_W-1:0]   accel_step_reg;
    logic [GAIN_W-1:0]   linear_gain_reg;
    logic [GAIN_W-1:0]   turn_gain_reg;
    logic [GAIN_W-1:0]   slip_gain_reg;
    logic [WEIGHT_W-1:0] grip_weight_a_reg;
    logic [WEIGHT_W-1:0] grip_weight_b_reg;
    logic [WEIGHT_W-1:0] grip_weight_c_reg;
    logic [DZ_W-1:0]     slip_deadzone_reg;

    // Sequencer and datapath.
    owsm_state_t              state_reg;
    owsm_state_t              state_next;
    owsm_cmd_t                cmd_reg;
    logic signed [RATE_W-1:0] ramped_x_reg;
    logic signed [RATE_W-1:0] ramp_out;
    logic                     slip_en_reg;
    logic signed [OPA_W-1:0]  opa;
    logic signed [OPB_W-1:0]  opb;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [OPA_W-1:0]  prod_narrow;
    logic signed [OPA_W-1:0]  x_half_neg;
    logic signed [OPA_W-1:0]  s_reg;
    logic signed [OPA_W-1:0]  a_reg;
    logic signed [OPA_W-1:0]  b_reg;
    logic signed [OPA_W-1:0]  c_reg;
    logic signed [ACC_W-1:0]  acc1_reg;
    logic signed [ACC_W-1:0]  acc2_reg;
    logic signed [ACC_W-1:0]  acc3_reg;
    logic signed [RATE_W:0]   yaw_ext;
    logic signed [RATE_W:0]   yaw_mag;
    logic                     cmd_transfer;
    logic                     rsp_load;

    // Output register.
    owsm_rsp_t rsp_reg;
    logic      rsp_valid_reg;

    assign cfg_ready    = 1'b1;
    assign cmd_transfer = cmd_valid && !cmd_stall;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_step_reg    <= ACCEL_STEP_RST;
            linear_gain_reg   <= LINEAR_GAIN_RST;
            turn_gain_reg     <= TURN_GAIN_RST;
            slip_gain_reg     <= SLIP_GAIN_RST;
            grip_weight_a_reg <= GRIP_WEIGHT_A_RST;
            grip_weight_b_reg <= GRIP_WEIGHT_B_RST;
            grip_weight_c_reg <= GRIP_WEIGHT_C_RST;
            slip_deadzone_reg <= SLIP_DEADZONE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ACCEL_STEP:    accel_step_reg    <= cfg_data[STEP_W-1:0];
                CFG_LINEAR_GAIN:   linear_gain_reg   <= cfg_data[GAIN_W-1:0];
                CFG_TURN_GAIN:     turn_gain_reg     <= cfg_data[GAIN_W-1:0];
                CFG_SLIP_GAIN:     slip_gain_reg     <= cfg_data[GAIN_W-1:0];
                CFG_GRIP_WEIGHT_A: grip_weight_a_reg <= cfg_data[WEIGHT_W-1:0];
                CFG_GRIP_WEIGHT_B: grip_weight_b_reg <= cfg_data[WEIGHT_W-1:0];
                CFG_GRIP_WEIGHT_C: grip_weight_c_reg <= cfg_data[WEIGHT_W-1:0];
                CFG_SLIP_DEADZONE: slip_deadzone_reg <= cfg_data[DZ_W-1:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Ramp limiter: the reference is updated at the cmd transfer and then
    // serves as the x rate for the rest of the tick.
    // ------------------------------------------------------------------
    owsm_ramp u_ramp (
        .target  (cmd.demand_x),
        .current (ramped_x_reg),
        .step    (accel_step_reg),
        .ramped  (ramp_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramped_x_reg <= '0;
        end
        else if (cmd_transfer)
        begin
            ramped_x_reg <= ramp_out;
        end
    end

    // Slip deadzone test on the incoming correction.
    always_comb
    begin
        yaw_ext = (RATE_W + 1)'(cmd.yaw_correction);
        yaw_mag = (yaw_ext < 0) ? -yaw_ext : yaw_ext;
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_transfer)
                begin
                    state_next = ST_TURN;
                end
            end
            ST_TURN:   state_next = ST_SLIP;
            ST_SLIP:   state_next = ST_LIN_Y;
            ST_LIN_Y:  state_next = ST_LIN_X;
            ST_LIN_X:  state_next = ST_WGT_A;
            ST_WGT_A:  state_next = ST_WGT_B;
            ST_WGT_B:  state_next = ST_WGT_C;
            ST_WGT_C:  state_next = ST_GAIN_A;
            ST_GAIN_A: state_next = ST_GAIN_B;
            ST_GAIN_B: state_next = ST_GAIN_C;
            ST_GAIN_C: state_next = ST_LAST;
            ST_LAST:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs. Each issue state picks the multiplier operands;
    // the product is used one state later.
    // ------------------------------------------------------------------
    always_comb
    begin
        opa       = '0;
        opb       = '0;
        rsp_load  = 1'b0;
        cmd_stall = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_TURN:
            begin
                opa = OPA_W'(cmd_reg.demand_turn);
                opb = $signed({1'b0, turn_gain_reg});
            end
            ST_SLIP:
            begin
                opa = OPA_W'(cmd_reg.yaw_correction);
                opb = $signed({1'b0, slip_gain_reg});
            end
            ST_LIN_Y:
            begin
                opa = OPA_W'(cmd_reg.demand_y);
                opb = $signed({{(OPB_W-WEIGHT_W){1'b0}}, SQRT3_HALF_Q14});
            end
            ST_LIN_X:
            begin
                opa = OPA_W'(ramped_x_reg);
                opb = $signed({{(OPB_W-WEIGHT_W){1'b0}}, SQRT3_HALF_Q14});
            end
            ST_WGT_A:
            begin
                opa = s_reg;
                opb = $signed({{(OPB_W-WEIGHT_W){1'b0}}, grip_weight_a_reg});
            end
            ST_WGT_B:
            begin
                opa = s_reg;
                opb = $signed({{(OPB_W-WEIGHT_W){1'b0}}, grip_weight_b_reg});
            end
            ST_WGT_C:
            begin
                opa = s_reg;
                opb = $signed({{(OPB_W-WEIGHT_W){1'b0}}, grip_weight_c_reg});
            end
            ST_GAIN_A:
            begin
                opa = a_reg;
                opb = $signed({1'b0, linear_gain_reg});
            end
            ST_GAIN_B:
            begin
                opa = b_reg;
                opb = $signed({1'b0, linear_gain_reg});
            end
            ST_GAIN_C:
            begin
                opa = c_reg;
                opb = $signed({1'b0, linear_gain_reg});
            end
            ST_DONE:
            begin
                // The result moves out when the output register is free or
                // is being emptied in this same cycle.
                rsp_load = !rsp_valid_reg || !rsp_stall;
            end
            default:
            begin
                opa = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Shared multiplier and wheel accumulators
    // ------------------------------------------------------------------
    always_comb
    begin
        prod_ext    = ACC_W'(prod_reg);
        prod_narrow = OPA_W'(prod_reg);
        x_half_neg  = -(OPA_W'(ramped_x_reg) <<< HALF_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_transfer)
                begin
                    cmd_reg     <= cmd;
                    slip_en_reg <= yaw_mag > $signed({2'b00, slip_deadzone_reg});
                end
            end
            ST_SLIP:
            begin
                // Turn term is common to all three wheels.
                acc1_reg <= prod_ext <<< TURN_SHIFT;
                acc2_reg <= prod_ext <<< TURN_SHIFT;
                acc3_reg <= prod_ext <<< TURN_SHIFT;
            end
            ST_LIN_Y:
            begin
                s_reg <= slip_en_reg ? prod_narrow : '0;
            end
            ST_LIN_X:
            begin
                a_reg <= x_half_neg + prod_narrow;
                b_reg <= x_half_neg - prod_narrow;
            end
            ST_WGT_A:  c_reg    <= prod_narrow;
            ST_WGT_B:  acc1_reg <= acc1_reg + (prod_ext <<< SLIP_SHIFT);
            ST_WGT_C:  acc2_reg <= acc2_reg - (prod_ext <<< SLIP_SHIFT);
            ST_GAIN_A: acc3_reg <= acc3_reg + (prod_ext <<< SLIP_SHIFT);
            ST_GAIN_B: acc1_reg <= acc1_reg + prod_ext;
            ST_GAIN_C: acc2_reg <= acc2_reg + prod_ext;
            ST_LAST:   acc3_reg <= acc3_reg + prod_ext;
            default:   ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register: rounding and saturation happen on the way in.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg.wheel_one_rpm   <= owsm_finish(acc1_reg);
            rsp_reg.wheel_two_rpm   <= owsm_finish(acc2_reg);
            rsp_reg.wheel_three_rpm <= owsm_finish(acc3_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

`ifndef NO_ASSERTIONS
    // Every accepted item reaches the finish step after a fixed schedule.
    a_fixed_schedule: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_transfer |-> ##12 (state_reg == ST_DONE))
        else $error("sequencer did not reach the finish step on schedule");

    // A new result only appears out of the finish step.
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_DONE))
        else $error("result became valid outside the finish step");

    // The ramp reference only moves at a cmd transfer.
    a_ramp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> $stable(ramped_x_reg))
        else $error("ramp reference changed while an item was in progress");
`endif

endmodule

FILE: rtl/owsm_ramp.sv
// ============================================================================
// Omni wheel speed mixer ramp limiter
// Ramps the kept x reference up by at most one step; slowing down takes the demand at once, a reversal gives zero.
// ============================================================================
module owsm_ramp (
    input  logic signed [owsm_pkg::RATE_W-1:0] target,
    input  logic signed [owsm_pkg::RATE_W-1:0] current,
    input  logic [owsm_pkg::STEP_W-1:0]        step,
    output logic signed [owsm_pkg::RATE_W-1:0] ramped
);
    import owsm_pkg::*;

    localparam int DIFF_W = RATE_W + 2;

    logic signed [DIFF_W-1:0] target_ext;
    logic signed [DIFF_W-1:0] current_ext;
    logic signed [DIFF_W-1:0] mag_target;
    logic signed [DIFF_W-1:0] mag_current;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] step_ext;
    logic signed [DIFF_W-1:0] diff_lim;
    logic signed [DIFF_W-1:0] moved;
    logic                     reversal;

    always_comb
    begin
        target_ext  = DIFF_W'(target);
        current_ext = DIFF_W'(current);
        mag_target  = (target_ext < 0) ? -target_ext : target_ext;
        mag_current = (current_ext < 0) ? -current_ext : current_ext;
        reversal    = ((target < 0) && (current > 0)) || ((target > 0) && (current < 0));
        step_ext    = $signed({{(DIFF_W-STEP_W){1'b0}}, step});
        diff        = target_ext - current_ext;
        if (diff > step_ext)
        begin
            diff_lim = step_ext;
        end
        else if (diff < -step_ext)
        begin
            diff_lim = -step_ext;
        end
        else
        begin
            diff_lim = diff;
        end
        moved = current_ext + diff_lim;

        // The stepped value always lies between reference and target.
        if (reversal)
        begin
            ramped = '0;
        end
        else if (mag_target > mag_current)
        begin
            ramped = moved[RATE_W-1:0];
        end
        else
        begin
            ramped = target;
        end
    end

endmodule
